// ----- hw/rtl/ptb_pkg.sv -----
// ----------------------------------------------------------------------------
// ptb_pkg: shared definitions for the palindromic tree builder
// Widths of the beat fields, root node numbers, sequencer states, defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package ptb_pkg;

   // beat field widths
   localparam int SYM_W = 8;
   localparam int OUT_W = 10;

   // default sizing
   localparam int DEF_MAX_LEN  = 512;
   localparam int DEF_ALPHABET = 256;

   // fixed node numbers
   localparam int IMAG_ROOT  = 1;
   localparam int EMPTY_ROOT = 2;
   localparam int FIRST_NODE = 3;

   // length-plus-one of the roots
   localparam int IMAG_LENP1  = 0;
   localparam int EMPTY_LENP1 = 1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOD_MUL,
      ST_MOD_FIX,
      ST_TEST,
      ST_CMP,
      ST_FOLLOW,
      ST_LINK,
      ST_EDGE_ADDR,
      ST_EDGE_RD,
      ST_EDGE_CHK,
      ST_EDGE_VAL,
      ST_CREATE,
      ST_FINISH,
      ST_DONE
   } ptb_state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/ptb_if.sv -----
// ----------------------------------------------------------------------------
// ptb_if: valid/ready channels of the palindromic tree builder
// Symbol request channel and result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptb_req_if;
   import ptb_pkg::*;

   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol;

   modport source (output valid, output symbol, input ready);
   modport sink   (input valid, input symbol, output ready);
endinterface

interface ptb_rsp_if;
   import ptb_pkg::*;

   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] node_index;
   logic [OUT_W-1:0] pal_length;
   logic             is_new;
   logic [OUT_W-1:0] distinct_count;
   logic [OUT_W-1:0] occurrences;
   logic             overflow;

   modport source (output valid, output node_index, output pal_length, output is_new,
                   output distinct_count, output occurrences, output overflow,
                   input ready);
   modport sink   (input valid, input node_index, input pal_length, input is_new,
                   input distinct_count, input occurrences, input overflow,
                   output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ptb_ram.sv -----
// ----------------------------------------------------------------------------
// ptb_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered. No reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/palindromic_tree_builder_unit.sv -----
// ----------------------------------------------------------------------------
// palindromic_tree_builder_unit: eertree builder over a symbol stream
// Appends each symbol, walks suffix links, follows or creates an edge and
// reports the longest palindromic suffix node after every symbol.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake                 beat contents
//   req_ch    in    req_ch.valid/ready        symbol
//   rsp_ch    out   rsp_ch.valid/ready        node_index, pal_length, is_new,
//                                             distinct_count, occurrences, overflow
//
// Steps: a symbol is reduced and stored (ST_MOD_MUL, ST_MOD_FIX), the starting
// node is tested, suffix-link hops follow (node read, length probe, text compare),
// then the edge lookup (address, read, range check, parent check) and the result
// load; a new node adds a create step, a second walk of the same kind and a node
// write. A symbol past MAX_LEN goes straight from idle to the result load.
// The single node RAM read port and the one probe subtractor serialise each hop:
// a hop reads the node store unless it leaves a root, and the text store only
// when the probe lands inside the stored text.
// Reset: synchronous, clears the sequencer and counters at once; no clearing
// pass. An edge entry counts only when it names an existing node whose stored
// parent and symbol match the lookup, so stale entries are ignored.
// Stalls: req_ch.ready is high only in idle; a result waiting on rsp_ch holds
// the next result in ST_DONE, and no new symbol is taken until it is accepted.
//
`default_nettype none

module palindromic_tree_builder_unit #(
   parameter int MAX_LEN  = ptb_pkg::DEF_MAX_LEN,
   parameter int ALPHABET = ptb_pkg::DEF_ALPHABET
) (
   input wire logic  clock,
   input wire logic  reset,
   ptb_req_if.sink   req_ch,
   ptb_rsp_if.source rsp_ch
);

   import ptb_pkg::*;

   // ------------------------------------------------------------------
   // sizing
   // ------------------------------------------------------------------
   localparam int NODE_SLOTS = MAX_LEN + 3;
   localparam int NODE_W     = $clog2(NODE_SLOTS);
   localparam int POS_W      = $clog2(MAX_LEN + 1);
   localparam int LEN_W      = $clog2(MAX_LEN + 2);
   localparam int TXT_AW     = $clog2(MAX_LEN);
   localparam int C_W        = $clog2(ALPHABET);
   localparam int EDGE_DEPTH = NODE_SLOTS * ALPHABET;
   localparam int EDGE_AW    = $clog2(EDGE_DEPTH);
   localparam int NODE_DW    = 3 * LEN_W + 2 * NODE_W + C_W;

   // symbol reduction: q = floor(sym * RECIP / 2^16) is the quotient or one less
   localparam logic [15:0]        RECIP     = 16'(65536 / ALPHABET);
   localparam logic [8:0]         ALPH_9    = 9'(ALPHABET);
   localparam logic [9:0]         ALPH_10   = 10'(ALPHABET);
   localparam logic [EDGE_AW-1:0] ALPH_E    = EDGE_AW'(ALPHABET);
   localparam logic [POS_W-1:0]   MAX_POS   = POS_W'(MAX_LEN);
   localparam logic [NODE_W:0]    SLOTS_X   = (NODE_W + 1)'(NODE_SLOTS);
   localparam logic [NODE_W-1:0]  N_IMAG    = NODE_W'(IMAG_ROOT);
   localparam logic [NODE_W-1:0]  N_EMPTY   = NODE_W'(EMPTY_ROOT);
   localparam logic [NODE_W-1:0]  N_FIRST   = NODE_W'(FIRST_NODE);
   localparam logic [LEN_W-1:0]   L_IMAG    = LEN_W'(IMAG_LENP1);
   localparam logic [LEN_W-1:0]   L_EMPTY   = LEN_W'(EMPTY_LENP1);

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   ptb_state_type state_ff, state_in;

   logic [POS_W-1:0]   pos_ff;            // symbols stored so far
   logic [NODE_W-1:0]  node_total_ff;     // highest node number in use
   logic [NODE_W-1:0]  last_node_ff;      // longest suffix node
   logic [LEN_W-1:0]   last_lenp1_ff;
   logic [LEN_W-1:0]   last_hits_ff;
   logic               phase2_ff;         // second walk: suffix link of new node

   logic [SYM_W-1:0]   sym_ff;
   logic [SYM_W-1:0]   q_ff;
   logic [C_W-1:0]     c_ff;
   logic [POS_W-1:0]   i_ff;
   logic [NODE_W-1:0]  cur_ff;
   logic [LEN_W-1:0]   cur_lenp1_ff;
   logic [EDGE_AW-1:0] edge_addr_ff;
   logic [NODE_W-1:0]  e_ff;
   logic [NODE_W-1:0]  nn_ff;
   logic [NODE_W-1:0]  par_ff;
   logic [LEN_W-1:0]   new_lenp1_ff;
   logic [NODE_W-1:0]  link_ff;
   logic [LEN_W-1:0]   link_lenp1_ff;
   logic               new_ff;
   logic               ovf_ff;

   logic               out_valid_ff;
   logic [OUT_W-1:0]   out_node_ff;
   logic [OUT_W-1:0]   out_len_ff;
   logic               out_new_ff;
   logic [OUT_W-1:0]   out_distinct_ff;
   logic [OUT_W-1:0]   out_occ_ff;
   logic               out_ovf_ff;

   // ------------------------------------------------------------------
   // memories
   // ------------------------------------------------------------------
   logic               txt_wr_en, txt_rd_en;
   logic [TXT_AW-1:0]  txt_rd_addr;
   logic [C_W-1:0]     txt_rd_data;
   logic [C_W-1:0]     c_in_fix;

   logic               edge_wr_en, edge_rd_en;
   logic [NODE_W-1:0]  edge_rd_data;
   logic [NODE_W-1:0]  nn_next;

   logic               node_wr_en, node_rd_en;
   logic [NODE_W-1:0]  node_wr_addr, node_rd_addr;
   logic [NODE_DW-1:0] node_wr_data, node_rd_data;

   ptb_ram #(.WIDTH(C_W), .DEPTH(MAX_LEN)) u_text_ram (
      .clock   (clock),
      .wr_en   (txt_wr_en),
      .wr_addr (pos_ff[TXT_AW-1:0]),
      .wr_data (c_in_fix),
      .rd_en   (txt_rd_en),
      .rd_addr (txt_rd_addr),
      .rd_data (txt_rd_data)
   );

   ptb_ram #(.WIDTH(NODE_W), .DEPTH(EDGE_DEPTH)) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_wr_en),
      .wr_addr (edge_addr_ff),
      .wr_data (nn_next),
      .rd_en   (edge_rd_en),
      .rd_addr (edge_addr_ff),
      .rd_data (edge_rd_data)
   );

   ptb_ram #(.WIDTH(NODE_DW), .DEPTH(NODE_SLOTS)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_wr_en),
      .wr_addr (node_wr_addr),
      .wr_data (node_wr_data),
      .rd_en   (node_rd_en),
      .rd_addr (node_rd_addr),
      .rd_data (node_rd_data)
   );

   // ------------------------------------------------------------------
   // node entry fields: {lenp1, link, link_lenp1, parent, sym, hits}
   // ------------------------------------------------------------------
   logic [LEN_W-1:0]  nd_lenp1, nd_link_lenp1, nd_hits;
   logic [NODE_W-1:0] nd_link, nd_parent;
   logic [C_W-1:0]    nd_sym;

   assign nd_hits       = node_rd_data[LEN_W-1:0];
   assign nd_sym        = node_rd_data[LEN_W +: C_W];
   assign nd_parent     = node_rd_data[LEN_W + C_W +: NODE_W];
   assign nd_link_lenp1 = node_rd_data[LEN_W + C_W + NODE_W +: LEN_W];
   assign nd_link       = node_rd_data[2 * LEN_W + C_W + NODE_W +: NODE_W];
   assign nd_lenp1      = node_rd_data[2 * LEN_W + C_W + 2 * NODE_W +: LEN_W];

   // ------------------------------------------------------------------
   // datapath status
   // ------------------------------------------------------------------
   logic [23:0]       mod_prod;
   logic [16:0]       mod_qa;
   logic [16:0]       mod_r17;
   logic [9:0]        mod_r;
   logic [LEN_W:0]    probe_diff;        // shared probe: i - lenp1
   logic              probe_borrow;
   logic              probe_root;        // lenp1 of zero: always extends
   logic              text_match;
   logic              cur_is_root;
   logic              edge_in_range;
   logic              edge_match;
   logic [NODE_W:0]   nn_wide;
   logic              room;
   logic              out_load;
   logic              req_fire;

   assign mod_prod = sym_ff * RECIP;
   assign mod_qa   = q_ff * ALPH_9;
   assign mod_r17  = 17'(sym_ff) - mod_qa;

   always_comb begin
      mod_r = mod_r17[9:0];
      if (mod_r >= ALPH_10) begin
         mod_r = mod_r - ALPH_10;
      end
   end

   assign c_in_fix      = mod_r[C_W-1:0];
   assign probe_diff    = {1'b0, LEN_W'(i_ff)} - {1'b0, cur_lenp1_ff};
   assign probe_borrow  = probe_diff[LEN_W];
   assign probe_root    = (cur_lenp1_ff == L_IMAG);
   assign text_match    = (txt_rd_data == c_ff);
   assign cur_is_root   = (cur_ff < N_FIRST);
   assign edge_in_range = (edge_rd_data >= N_FIRST) && (edge_rd_data <= node_total_ff);
   assign edge_match    = (nd_parent == cur_ff) && (nd_sym == c_ff);
   assign nn_wide       = {1'b0, node_total_ff} + (NODE_W + 1)'(1);
   assign room          = (nn_wide < SLOTS_X);
   assign nn_next       = nn_wide[NODE_W-1:0];
   assign req_fire      = req_ch.valid && req_ch.ready;
   assign out_load      = (state_ff == ST_DONE) && (!out_valid_ff || rsp_ch.ready);

   // ------------------------------------------------------------------
   // sequencer: next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = (pos_ff == MAX_POS) ? ST_DONE : ST_MOD_MUL;
            end
         end
         ST_MOD_MUL: state_in = ST_MOD_FIX;
         ST_MOD_FIX: state_in = ST_TEST;
         ST_TEST: begin
            if (probe_root) begin
               state_in = ST_EDGE_ADDR;
            end else if (probe_borrow) begin
               state_in = ST_FOLLOW;
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_CMP:       state_in = text_match ? ST_EDGE_ADDR : ST_FOLLOW;
         ST_FOLLOW:    state_in = cur_is_root ? ST_TEST : ST_LINK;
         ST_LINK:      state_in = ST_TEST;
         ST_EDGE_ADDR: state_in = ST_EDGE_RD;
         ST_EDGE_RD:   state_in = ST_EDGE_CHK;
         ST_EDGE_CHK: begin
            if (edge_in_range) begin
               state_in = ST_EDGE_VAL;
            end else begin
               state_in = phase2_ff ? ST_FINISH : ST_CREATE;
            end
         end
         ST_EDGE_VAL: begin
            if (phase2_ff) begin
               state_in = ST_FINISH;
            end else begin
               state_in = edge_match ? ST_DONE : ST_CREATE;
            end
         end
         ST_CREATE: begin
            if (!room) begin
               state_in = ST_DONE;
            end else if (cur_lenp1_ff == L_IMAG) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_FOLLOW;
            end
         end
         ST_FINISH: state_in = ST_DONE;
         ST_DONE: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // sequencer: memory strobes and handshake
   // ------------------------------------------------------------------
   always_comb begin
      req_ch.ready = 1'b0;
      txt_wr_en    = 1'b0;
      txt_rd_en    = 1'b0;
      txt_rd_addr  = probe_diff[TXT_AW-1:0];
      edge_wr_en   = 1'b0;
      edge_rd_en   = 1'b0;
      node_wr_en   = 1'b0;
      node_rd_en   = 1'b0;
      node_wr_addr = nn_ff;
      node_rd_addr = cur_ff;
      node_wr_data = {new_lenp1_ff, link_ff, link_lenp1_ff, par_ff, c_ff, LEN_W'(1)};
      unique case (state_ff)
         ST_IDLE:    req_ch.ready = 1'b1;
         ST_MOD_FIX: txt_wr_en = 1'b1;
         ST_TEST:    txt_rd_en = !probe_root && !probe_borrow;
         ST_FOLLOW:  node_rd_en = !cur_is_root;
         ST_EDGE_RD: edge_rd_en = 1'b1;
         ST_EDGE_CHK: begin
            node_rd_en   = edge_in_range;
            node_rd_addr = edge_rd_data;
         end
         ST_EDGE_VAL: begin
            // hit on an existing node: bump its count
            node_wr_en   = !phase2_ff && edge_match;
            node_wr_addr = e_ff;
            node_wr_data = {nd_lenp1, nd_link, nd_link_lenp1, nd_parent, nd_sym,
                            nd_hits + LEN_W'(1)};
         end
         ST_CREATE:  edge_wr_en = room;
         ST_FINISH:  node_wr_en = 1'b1;
         default: ;
      endcase
   end

   // ------------------------------------------------------------------
   // control registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pos_ff        <= '0;
         node_total_ff <= N_EMPTY;
         last_node_ff  <= N_EMPTY;
         last_lenp1_ff <= L_EMPTY;
         last_hits_ff  <= '0;
         phase2_ff     <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               phase2_ff <= 1'b0;
            end
            ST_MOD_FIX: begin
               pos_ff <= pos_ff + POS_W'(1);
            end
            ST_EDGE_VAL: begin
               if (!phase2_ff && edge_match) begin
                  last_node_ff  <= e_ff;
                  last_lenp1_ff <= nd_lenp1;
                  last_hits_ff  <= nd_hits + LEN_W'(1);
               end
            end
            ST_CREATE: begin
               if (room && cur_lenp1_ff != L_IMAG) begin
                  phase2_ff <= 1'b1;
               end
            end
            ST_FINISH: begin
               node_total_ff <= nn_ff;
               last_node_ff  <= nn_ff;
               last_lenp1_ff <= new_lenp1_ff;
               last_hits_ff  <= LEN_W'(1);
            end
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // working registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_fire) begin
         sym_ff <= req_ch.symbol;
         new_ff <= 1'b0;
         ovf_ff <= (pos_ff == MAX_POS);
      end
      unique case (state_ff)
         ST_MOD_MUL: q_ff <= mod_prod[23:16];
         ST_MOD_FIX: begin
            c_ff         <= c_in_fix;
            i_ff         <= pos_ff;
            cur_ff       <= last_node_ff;
            cur_lenp1_ff <= last_lenp1_ff;
         end
         ST_FOLLOW: begin
            // roots both link to the imaginary root
            if (cur_is_root) begin
               cur_ff       <= N_IMAG;
               cur_lenp1_ff <= L_IMAG;
            end
         end
         ST_LINK: begin
            cur_ff       <= nd_link;
            cur_lenp1_ff <= nd_link_lenp1;
         end
         ST_EDGE_ADDR: edge_addr_ff <= EDGE_AW'(cur_ff) * ALPH_E + EDGE_AW'(c_ff);
         ST_EDGE_CHK: begin
            e_ff <= edge_rd_data;
            if (!edge_in_range) begin
               link_ff       <= N_EMPTY;
               link_lenp1_ff <= L_EMPTY;
            end
         end
         ST_EDGE_VAL: begin
            if (phase2_ff) begin
               link_ff       <= edge_match ? e_ff : N_EMPTY;
               link_lenp1_ff <= edge_match ? nd_lenp1 : L_EMPTY;
            end
         end
         ST_CREATE: begin
            if (room) begin
               new_ff        <= 1'b1;
               nn_ff         <= nn_next;
               par_ff        <= cur_ff;
               new_lenp1_ff  <= cur_lenp1_ff + LEN_W'(2);
               link_ff       <= N_EMPTY;
               link_lenp1_ff <= L_EMPTY;
            end
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------------------
   // result register: load once the previous beat has been taken
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_node_ff     <= OUT_W'(last_node_ff);
         out_len_ff      <= OUT_W'(last_lenp1_ff - LEN_W'(1));
         out_new_ff      <= new_ff;
         out_distinct_ff <= OUT_W'(node_total_ff - N_EMPTY);
         out_occ_ff      <= OUT_W'(last_hits_ff);
         out_ovf_ff      <= ovf_ff;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.node_index     = out_node_ff;
   assign rsp_ch.pal_length     = out_len_ff;
   assign rsp_ch.is_new         = out_new_ff;
   assign rsp_ch.distinct_count = out_distinct_ff;
   assign rsp_ch.occurrences    = out_occ_ff;
   assign rsp_ch.overflow       = out_ovf_ff;

endmodule

`default_nettype wire

// ----- tb/palindromic_tree_builder_unit_chk.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palindromic_tree_builder_unit_chk: eertree predictor and result compare
// Watches the symbol and result channels, rebuilds the palindromic tree on
// every accepted symbol beat and checks each result beat field by field.
// ----------------------------------------------------------------------------
module palindromic_tree_builder_unit_chk (
   input  logic clock,
   input  logic reset,
   ptb_req_if   req_ch,
   ptb_rsp_if   rsp_ch,
   output int   fail_count,
   output int   outstanding
);

   import ptb_pkg::*;

   localparam int NODE_SLOTS = DEF_MAX_LEN + 3;

   typedef struct packed {
      logic [OUT_W-1:0] node_index;
      logic [OUT_W-1:0] pal_length;
      logic             is_new;
      logic [OUT_W-1:0] distinct_count;
      logic [OUT_W-1:0] occurrences;
      logic             overflow;
   } suffix_beat_type;

   logic [SYM_W-1:0] text [DEF_MAX_LEN];
   int               text_len;
   int               lenp1 [NODE_SLOTS];
   int               link  [NODE_SLOTS];
   int               hits  [NODE_SLOTS];
   logic [OUT_W-1:0] edge_tab [NODE_SLOTS * DEF_ALPHABET];
   int               last_node;
   int               node_total;
   int               errors;
   suffix_beat_type  suffix_q [$];

   // palindrome at node v, ending just before i, grows by the symbol at i
   function automatic bit extends_at(int i, int v);
      int p;
      p = i - lenp1[v];
      if (p < 0) return 1'b0;
      return text[p] == text[i];
   endfunction

   function automatic suffix_beat_type append_symbol(logic [SYM_W-1:0] sym);
      int              c;
      int              i;
      int              cur;
      int              guard;
      int              nn;
      int              t;
      suffix_beat_type r;
      r = '0;
      c = int'(sym) % DEF_ALPHABET;
      if (text_len >= DEF_MAX_LEN) begin
         r.overflow = 1'b1;
      end else begin
         i           = text_len;
         cur         = last_node;
         text[i]     = SYM_W'(c);
         text_len    = i + 1;
         for (guard = 0; !extends_at(i, cur) && guard < NODE_SLOTS; guard++)
            cur = link[cur] % NODE_SLOTS;
         if (!extends_at(i, cur)) cur = IMAG_ROOT;
         t = int'(edge_tab[cur * DEF_ALPHABET + c]);
         if (t != 0) begin
            last_node = t % NODE_SLOTS;
            hits[last_node]++;
         end else if (node_total + 1 < NODE_SLOTS) begin
            node_total++;
            nn                              = node_total;
            edge_tab[cur * DEF_ALPHABET + c] = OUT_W'(nn);
            last_node                       = nn;
            r.is_new                        = 1'b1;
            lenp1[nn]                       = lenp1[cur] + 2;
            hits[nn]                        = 1;
            link[nn]                        = EMPTY_ROOT;
            // single-symbol palindromes always link to the empty root
            if (lenp1[nn] != 2) begin
               for (guard = 0; cur > IMAG_ROOT && guard < NODE_SLOTS; guard++) begin
                  cur = link[cur] % NODE_SLOTS;
                  if (extends_at(i, cur)) begin
                     t        = int'(edge_tab[cur * DEF_ALPHABET + c]);
                     link[nn] = (t != 0) ? t % NODE_SLOTS : EMPTY_ROOT;
                     break;
                  end
               end
            end
         end
      end
      r.node_index     = OUT_W'(last_node);
      r.pal_length     = OUT_W'(lenp1[last_node] - 1);
      r.distinct_count = OUT_W'(node_total - 2);
      r.occurrences    = OUT_W'(hits[last_node]);
      return r;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      suffix_beat_type want;
      if (reset) begin
         foreach (text[k]) text[k] = '0;
         foreach (lenp1[k]) begin
            lenp1[k] = 0;
            link[k]  = 0;
            hits[k]  = 0;
         end
         foreach (edge_tab[k]) edge_tab[k] = '0;
         lenp1[EMPTY_ROOT] = EMPTY_LENP1;
         lenp1[IMAG_ROOT]  = IMAG_LENP1;
         link[IMAG_ROOT]   = IMAG_ROOT;
         link[EMPTY_ROOT]  = IMAG_ROOT;
         text_len          = 0;
         last_node         = EMPTY_ROOT;
         node_total        = 2;
         errors            = 0;
         suffix_q.delete();
      end else begin
         // compare before predicting: a result never leaves in its own beat's cycle
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (suffix_q.size() == 0) begin
               $error("unexpected result beat: node_index %0d", rsp_ch.node_index);
               errors++;
            end else begin
               want = suffix_q.pop_front();
               check_field("node_index", int'(want.node_index), int'(rsp_ch.node_index));
               check_field("pal_length", int'(want.pal_length), int'(rsp_ch.pal_length));
               check_field("is_new", int'(want.is_new), int'(rsp_ch.is_new));
               check_field("distinct_count", int'(want.distinct_count),
                           int'(rsp_ch.distinct_count));
               check_field("occurrences", int'(want.occurrences), int'(rsp_ch.occurrences));
               check_field("overflow", int'(want.overflow), int'(rsp_ch.overflow));
            end
         end
         if (req_ch.valid && req_ch.ready)
            suffix_q.push_back(append_symbol(req_ch.symbol));
      end
      fail_count  <= errors;
      outstanding <= suffix_q.size();
   end

endmodule

// ----- tb/palindromic_tree_builder_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palindromic_tree_builder_unit_tb: symbol stream stimulus and verdict
// Fills the text store with palindrome-rich symbol runs, then pushes past
// the store limit; random gaps and backpressure on both channels.
// ----------------------------------------------------------------------------
module palindromic_tree_builder_unit_tb;
   import ptb_pkg::*;

   localparam int ITEMS = 2000;

   logic clock;
   logic reset = 1'b1;
   bit   calm  = 1'b0;
   int   fail_count;
   int   outstanding;

   ptb_req_if sym_ch ();
   ptb_rsp_if suffix_ch ();

   palindromic_tree_builder_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (sym_ch),
      .rsp_ch (suffix_ch)
   );

   palindromic_tree_builder_unit_chk u_chk (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (sym_ch),
      .rsp_ch      (suffix_ch),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hold reset at the start, then release it for good
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // result backpressure: drop ready at random, about a fifth of the time, never while calm
   always @(posedge clock) begin
      suffix_ch.ready <= !reset && (calm || $urandom_range(99) >= 20);
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      logic [SYM_W-1:0] plan [$];
      logic [SYM_W-1:0] half [$];
      logic [SYM_W-1:0] sym_a;
      logic [SYM_W-1:0] sym_b;
      int               kind;
      int               n;
      int               period;
      int               k;
      int               idx;
      bit               quiet;

      sym_ch.valid  <= 1'b0;
      sym_ch.symbol <= '0;

      // directed opening: growing runs of one symbol, the extreme codes,
      // alternating bit patterns and a nested palindrome
      plan = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF,
               8'h5A, 8'hA5, 8'h5A, 8'h00, 8'h80, 8'h01, 8'h7F, 8'h80, 8'hFE,
               8'hFE, 8'hFE, 8'hFE, 8'h01, 8'hFE, 8'hFE, 8'h01};

      // random body: mostly palindromes, runs and periodic strings over a
      // two-symbol alphabet that changes now and then, some plain noise;
      // keeping the pair across segments lets palindromes span them
      sym_a = SYM_W'($urandom_range(255));
      sym_b = SYM_W'($urandom_range(255));
      while (plan.size() < DEF_MAX_LEN) begin
         if ($urandom_range(9) == 0) begin
            sym_a = SYM_W'($urandom_range(255));
            sym_b = SYM_W'($urandom_range(255));
         end
         kind = $urandom_range(99);
         if (kind < 50) begin
            n = $urandom_range(1, 24);
            half.delete();
            for (k = 0; k < n / 2; k++) half.push_back($urandom_range(1) ? sym_a : sym_b);
            for (k = 0; k < half.size(); k++) plan.push_back(half[k]);
            if (n % 2) plan.push_back($urandom_range(1) ? sym_a : sym_b);
            for (k = half.size() - 1; k >= 0; k--) plan.push_back(half[k]);
         end else if (kind < 72) begin
            // an occasional long run drives pal_length high
            n = ($urandom_range(29) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 30);
            repeat (n) plan.push_back(sym_a);
         end else if (kind < 87) begin
            period = $urandom_range(1, 4);
            n      = $urandom_range(4, 30);
            half.delete();
            for (k = 0; k < period; k++) half.push_back($urandom_range(1) ? sym_a : sym_b);
            for (k = 0; k < n; k++) plan.push_back(half[k % period]);
         end else begin
            repeat ($urandom_range(1, 8)) plan.push_back(SYM_W'($urandom_range(255)));
         end
      end
      while (plan.size() > DEF_MAX_LEN) void'(plan.pop_back());

      // the store is full now: every further beat must come back flagged
      repeat (ITEMS - DEF_MAX_LEN) plan.push_back(SYM_W'($urandom_range(255)));

      while (reset) @(posedge clock);

      for (idx = 0; idx < plan.size(); idx++) begin
         // a stretch of the stream (beats 150 to 299) runs with no gaps and no backpressure
         quiet = (idx >= 150 && idx < 300);
         calm <= quiet;
         if (!quiet) begin
            while ($urandom_range(99) < 20) begin
               sym_ch.valid <= 1'b0;
               @(posedge clock);
            end
         end
         // hold valid and the symbol until the block takes the beat
         sym_ch.valid  <= 1'b1;
         sym_ch.symbol <= plan[idx];
         @(posedge clock);
         while (!sym_ch.ready) @(posedge clock);
      end
      sym_ch.valid <= 1'b0;
      calm         <= 1'b0;

      // let the last beat reach the checker, drain, then watch for strays
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
